// ===== src/clet_pkg.sv =====
// Package for the console line editor and tokenizer.
// Holds byte codes, result kinds and the command/status types shared by
// the controller and the datapath. No dependencies.
package clet_pkg;

  localparam int unsigned LEN_W  = 6;
  localparam int unsigned ARGC_W = 4;
  localparam int unsigned TOK_W  = 3;

  localparam logic [1:0] KIND_ECHO    = 2'd0;
  localparam logic [1:0] KIND_TOKBYTE = 2'd1;
  localparam logic [1:0] KIND_TOKEND  = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam logic [7:0] CH_EOT   = 8'h04;
  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  typedef enum logic [2:0] {
    SRC_ZERO,
    SRC_RX,
    SRC_BS,
    SRC_SP,
    SRC_CR,
    SRC_LF,
    SRC_MEM
  } src_e;

  typedef struct packed {
    logic       store;
    logic       erase;
    logic       clr_len;
    logic       set_disc;
    logic       cr_we;
    logic       cr_val;
    logic       start_walk;
    logic       adv_p;
    logic       tog_quote;
    logic       clr_quote;
    logic       inc_argc;
    logic       emit;
    logic [1:0] kind;
    src_e       src;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic is_cr;
    logic is_lf;
    logic is_bs;
    logic is_eot;
    logic is_print;
    logic len_zero;
    logic len_full;
    logic cr_seen;
    logic echo_en;
    logic at_end;
    logic argc_max;
    logic rd_blank;
    logic rd_quote;
    logic quoted;
    logic out_free;
  } status_t;

endpackage

// ===== src/console_line_editor_tokenizer_core.sv =====
// Top level of the console line editor and tokenizer.
// Instantiates clet_ctrl and clet_dp; depends on clet_pkg.
//
//   channel | dir | handshake                  | payload
//   cfg     | in  | cfg_we_i                   | cfg_wdata_i (echo enable)
//   in      | in  | in_valid_i / in_stall_o    | rx_byte_i
//   out     | out | out_valid_o / out_stall_i  | kind, out_byte, token_index,
//           |     |                            | prompt_wanted, disconnected, last
//
// One byte is taken per cycle while idle; a byte without a result keeps it idle.
// An echoed byte gives its echo, an echoed erase gives backspace, space, backspace;
// a line end gives CR, LF, the token bytes and token ends of the walk, then line done.
// Reset clears length and flags and sets echo on; the line memory is not cleared.
// A stalled output holds the walk at its next result; input stalls until all
// results of the current byte are in the output register.
module console_line_editor_tokenizer_core #(
  parameter int unsigned LINE_MAX = 48,
  parameter int unsigned MAX_ARGS = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] kind_o,
  output logic [7:0] out_byte_o,
  output logic [2:0] token_index_o,
  output logic       prompt_wanted_o,
  output logic       disconnected_o,
  output logic       last_o
);

  clet_pkg::cmd_t    cmd;
  clet_pkg::status_t status;

  clet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  clet_dp #(
    .LINE_MAX (LINE_MAX),
    .MAX_ARGS (MAX_ARGS)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .out_byte_o      (out_byte_o),
    .token_index_o   (token_index_o),
    .prompt_wanted_o (prompt_wanted_o),
    .disconnected_o  (disconnected_o),
    .last_o          (last_o)
  );

endmodule

// ===== src/clet_dp.sv =====
// Datapath of the console line editor: line memory, length, flags,
// tokenizer walk pointer and the result register.
// Depends on clet_pkg; driven by clet_ctrl through clet_pkg::cmd_t.
module clet_dp #(
  parameter int unsigned LINE_MAX = 48,
  parameter int unsigned MAX_ARGS = 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_wdata_i,
  input  logic [7:0]               rx_byte_i,
  input  clet_pkg::cmd_t           cmd_i,
  output clet_pkg::status_t        status_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [1:0]               kind_o,
  output logic [7:0]               out_byte_o,
  output logic [clet_pkg::TOK_W-1:0] token_index_o,
  output logic                     prompt_wanted_o,
  output logic                     disconnected_o,
  output logic                     last_o
);

  localparam int unsigned AW = (LINE_MAX > 1) ? $clog2(LINE_MAX) : 1;

  logic [7:0]                   mem [LINE_MAX];
  logic [7:0]                   rd_q;
  logic [7:0]                   rx_q;
  logic [clet_pkg::LEN_W-1:0]   len_q, len_d;
  logic [clet_pkg::LEN_W-1:0]   p_q, p_d;
  logic [clet_pkg::ARGC_W-1:0]  argc_q, argc_d;
  logic                         quoted_q, quoted_d;
  logic                         cr_q, disc_q, echo_q;
  logic                         out_valid_q;
  logic [1:0]                   kind_q;
  logic [7:0]                   byte_q, byte_d;
  logic [clet_pkg::TOK_W-1:0]   tok_q;
  logic                         prompt_q, discout_q, last_q;
  logic                         out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    len_d = len_q;
    if (cmd_i.clr_len) begin
      len_d = '0;
    end else if (cmd_i.store) begin
      len_d = len_q + 1'b1;
    end else if (cmd_i.erase) begin
      len_d = len_q - 1'b1;
    end
  end

  always_comb begin
    p_d    = p_q;
    argc_d = argc_q;
    quoted_d = quoted_q;
    if (cmd_i.start_walk) begin
      p_d      = '0;
      argc_d   = '0;
      quoted_d = 1'b0;
    end else begin
      if (cmd_i.adv_p) p_d = p_q + 1'b1;
      if (cmd_i.inc_argc) argc_d = argc_q + 1'b1;
      if (cmd_i.clr_quote) begin
        quoted_d = 1'b0;
      end else if (cmd_i.tog_quote) begin
        quoted_d = !quoted_q;
      end
    end
  end

  always_comb begin
    unique case (cmd_i.src)
      clet_pkg::SRC_RX:  byte_d = rx_q;
      clet_pkg::SRC_BS:  byte_d = clet_pkg::CH_BS;
      clet_pkg::SRC_SP:  byte_d = clet_pkg::CH_SP;
      clet_pkg::SRC_CR:  byte_d = clet_pkg::CH_CR;
      clet_pkg::SRC_LF:  byte_d = clet_pkg::CH_LF;
      clet_pkg::SRC_MEM: byte_d = rd_q;
      default:           byte_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      mem[len_q[AW-1:0]] <= rx_byte_i;
    end
    if (p_d < clet_pkg::LEN_W'(LINE_MAX)) begin
      rd_q <= mem[p_d[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      p_q         <= '0;
      argc_q      <= '0;
      quoted_q    <= 1'b0;
      cr_q        <= 1'b0;
      disc_q      <= 1'b0;
      echo_q      <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      len_q    <= len_d;
      p_q      <= p_d;
      argc_q   <= argc_d;
      quoted_q <= quoted_d;
      if (cmd_i.cr_we) cr_q <= cmd_i.cr_val;
      if (cmd_i.set_disc) disc_q <= 1'b1;
      if (cfg_we_i) echo_q <= cfg_wdata_i;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.store || cmd_i.erase || cmd_i.start_walk || cmd_i.cr_we) begin
      rx_q <= rx_byte_i;
    end
    if (cmd_i.emit) begin
      kind_q    <= cmd_i.kind;
      byte_q    <= byte_d;
      tok_q     <= (cmd_i.kind == clet_pkg::KIND_TOKBYTE ||
                    cmd_i.kind == clet_pkg::KIND_TOKEND) ? argc_q[clet_pkg::TOK_W-1:0] : '0;
      prompt_q  <= (cmd_i.kind == clet_pkg::KIND_DONE) ? !disc_q : 1'b0;
      discout_q <= disc_q;
      last_q    <= cmd_i.last;
    end
  end

  always_comb begin
    status_o.is_cr    = (rx_byte_i == clet_pkg::CH_CR);
    status_o.is_lf    = (rx_byte_i == clet_pkg::CH_LF);
    status_o.is_bs    = (rx_byte_i == clet_pkg::CH_BS) || (rx_byte_i == clet_pkg::CH_DEL);
    status_o.is_eot   = (rx_byte_i == clet_pkg::CH_EOT);
    status_o.is_print = (rx_byte_i >= clet_pkg::CH_SP) && (rx_byte_i <= clet_pkg::CH_TILDE);
    status_o.len_zero = (len_q == '0);
    status_o.len_full = (len_q >= clet_pkg::LEN_W'(LINE_MAX));
    status_o.cr_seen  = cr_q;
    status_o.echo_en  = echo_q;
    status_o.at_end   = (p_q >= len_q);
    status_o.argc_max = (argc_q == clet_pkg::ARGC_W'(MAX_ARGS));
    status_o.rd_blank = (rd_q == clet_pkg::CH_SP) || (rd_q == clet_pkg::CH_TAB);
    status_o.rd_quote = (rd_q == clet_pkg::CH_QUOTE);
    status_o.quoted   = quoted_q;
    status_o.out_free = out_free;
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = kind_q;
  assign out_byte_o      = byte_q;
  assign token_index_o   = tok_q;
  assign prompt_wanted_o = prompt_q;
  assign disconnected_o  = discout_q;
  assign last_o          = last_q;

endmodule

// ===== src/clet_ctrl.sv =====
// Controller of the console line editor: input handshake, byte dispatch
// and the sequence of echo, token walk and line-done results.
// Depends on clet_pkg; drives clet_dp through clet_pkg::cmd_t.
module clet_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  clet_pkg::status_t status_i,
  output clet_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ECHO   = 4'd1;
  localparam logic [3:0] S_ER_BS1 = 4'd2;
  localparam logic [3:0] S_ER_SP  = 4'd3;
  localparam logic [3:0] S_ER_BS2 = 4'd4;
  localparam logic [3:0] S_CR     = 4'd5;
  localparam logic [3:0] S_LF     = 4'd6;
  localparam logic [3:0] S_SKIP   = 4'd7;
  localparam logic [3:0] S_TOK    = 4'd8;
  localparam logic [3:0] S_DONE   = 4'd9;

  logic [3:0] state_q, state_d;
  logic       free;

  assign free       = status_i.out_free;
  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.kind = clet_pkg::KIND_ECHO;
    cmd_o.src  = clet_pkg::SRC_ZERO;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (status_i.is_cr || status_i.is_lf) begin
            cmd_o.cr_we = 1'b1;
            if (!(status_i.is_lf && status_i.cr_seen)) begin
              cmd_o.cr_val     = status_i.is_cr;
              cmd_o.start_walk = 1'b1;
              state_d          = S_CR;
            end
          end else begin
            cmd_o.cr_we = 1'b1;
            if (status_i.is_bs) begin
              if (!status_i.len_zero) begin
                cmd_o.erase = 1'b1;
                if (status_i.echo_en) state_d = S_ER_BS1;
              end
            end else if (status_i.is_eot) begin
              cmd_o.set_disc = 1'b1;
            end else if (status_i.is_print && !status_i.len_full) begin
              cmd_o.store = 1'b1;
              if (status_i.echo_en) state_d = S_ECHO;
            end
          end
        end
      end
      S_ECHO: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = clet_pkg::SRC_RX;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_ER_BS1: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = clet_pkg::SRC_BS;
          state_d    = S_ER_SP;
        end
      end
      S_ER_SP: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = clet_pkg::SRC_SP;
          state_d    = S_ER_BS2;
        end
      end
      S_ER_BS2: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = clet_pkg::SRC_BS;
          cmd_o.last = 1'b1;
          state_d    = S_IDLE;
        end
      end
      S_CR: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = clet_pkg::SRC_CR;
          state_d    = S_LF;
        end
      end
      S_LF: begin
        if (free) begin
          cmd_o.emit = 1'b1;
          cmd_o.src  = clet_pkg::SRC_LF;
          state_d    = S_SKIP;
        end
      end
      S_SKIP: begin
        if (status_i.argc_max || status_i.at_end) begin
          state_d = S_DONE;
        end else if (status_i.rd_blank) begin
          cmd_o.adv_p = 1'b1;
        end else if (status_i.rd_quote) begin
          cmd_o.tog_quote = 1'b1;
          cmd_o.adv_p     = 1'b1;
          state_d         = S_TOK;
        end else if (free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.kind  = clet_pkg::KIND_TOKBYTE;
          cmd_o.src   = clet_pkg::SRC_MEM;
          cmd_o.adv_p = 1'b1;
          state_d     = S_TOK;
        end
      end
      S_TOK: begin
        if (status_i.at_end) begin
          if (free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.kind      = clet_pkg::KIND_TOKEND;
            cmd_o.inc_argc  = 1'b1;
            cmd_o.clr_quote = 1'b1;
            state_d         = S_SKIP;
          end
        end else if (status_i.rd_quote) begin
          cmd_o.tog_quote = 1'b1;
          cmd_o.adv_p     = 1'b1;
        end else if (!status_i.quoted && status_i.rd_blank) begin
          if (free) begin
            cmd_o.emit      = 1'b1;
            cmd_o.kind      = clet_pkg::KIND_TOKEND;
            cmd_o.inc_argc  = 1'b1;
            cmd_o.clr_quote = 1'b1;
            cmd_o.adv_p     = 1'b1;
            state_d         = S_SKIP;
          end
        end else if (free) begin
          cmd_o.emit  = 1'b1;
          cmd_o.kind  = clet_pkg::KIND_TOKBYTE;
          cmd_o.src   = clet_pkg::SRC_MEM;
          cmd_o.adv_p = 1'b1;
        end
      end
      S_DONE: begin
        if (free) begin
          cmd_o.emit    = 1'b1;
          cmd_o.kind    = clet_pkg::KIND_DONE;
          cmd_o.last    = 1'b1;
          cmd_o.clr_len = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/clet_chk.sv =====
// Port checker for the console line editor and tokenizer.
// Depends on clet_pkg; bound to console_line_editor_tokenizer_core below.
module clet_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] kind_o,
  input logic [7:0] out_byte_o,
  input logic [2:0] token_index_o,
  input logic       prompt_wanted_o,
  input logic       disconnected_o,
  input logic       last_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable({kind_o, out_byte_o, token_index_o,
                                           prompt_wanted_o, disconnected_o, last_o}))
    else $error("stalled result changed");

  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == clet_pkg::KIND_DONE |->
      last_o && out_byte_o == 8'h00 && prompt_wanted_o == !disconnected_o)
    else $error("line done malformed");

  a_echo_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == clet_pkg::KIND_ECHO |->
      token_index_o == 3'd0 && !prompt_wanted_o)
    else $error("echo carries token fields");

  a_tokend_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == clet_pkg::KIND_TOKEND |-> out_byte_o == 8'h00 && !last_o)
    else $error("token end malformed");

endmodule

bind console_line_editor_tokenizer_core clet_chk u_clet_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .kind_o          (kind_o),
  .out_byte_o      (out_byte_o),
  .token_index_o   (token_index_o),
  .prompt_wanted_o (prompt_wanted_o),
  .disconnected_o  (disconnected_o),
  .last_o          (last_o)
);

// ===== tb/tb.sv =====
// Self-checking testbench for console_line_editor_tokenizer_core.
// Predicts echo, token and line-done transfers for every typed byte; uses clet_pkg.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned LINE_CAP    = 48;
  localparam int unsigned ARG_CAP     = 8;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic [2:0] tok;
    logic       prompt;
    logic       disc;
    logic       fin;
  } console_out_t;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  logic       cfg_wdata = 1'b0;
  logic       in_valid  = 1'b0;
  logic [7:0] rx_byte   = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [1:0] kind_w;
  logic [7:0] byte_w;
  logic [2:0] tok_w;
  logic       prompt_w;
  logic       disc_w;
  logic       fin_w;

  logic [7:0]   line_buf [LINE_CAP];
  int unsigned  line_len    = 0;
  bit           cr_pending  = 1'b0;
  bit           hangup      = 1'b0;
  bit           echo_on     = 1'b1;
  console_out_t burst[$];
  console_out_t awaited[$];
  logic [7:0]   rx_stream[$];

  bit          calm      = 1'b0;
  bit          eot_ok    = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned hold_left = 0;
  int unsigned quiet     = 0;
  int unsigned queued    = 0;
  int unsigned rx_done   = 0;
  int unsigned out_done  = 0;
  int unsigned mismatches   = 0;
  int unsigned lines_closed = 0;
  int unsigned tokens_made  = 0;
  int unsigned full_drops   = 0;
  int unsigned erases       = 0;

  always #10 clk = ~clk;

  console_line_editor_tokenizer_core #(
    .LINE_MAX(LINE_CAP),
    .MAX_ARGS(ARG_CAP)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .rx_byte_i      (rx_byte),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .kind_o         (kind_w),
    .out_byte_o     (byte_w),
    .token_index_o  (tok_w),
    .prompt_wanted_o(prompt_w),
    .disconnected_o (disc_w),
    .last_o         (fin_w)
  );

  function automatic bit is_blank(logic [7:0] c);
    return (c == clet_pkg::CH_SP) || (c == clet_pkg::CH_TAB);
  endfunction

  function automatic void put(logic [1:0] k, logic [7:0] d, int unsigned t, bit p);
    console_out_t r;
    r.kind   = k;
    r.data   = d;
    r.tok    = t[2:0];
    r.prompt = p;
    r.disc   = hangup;
    r.fin    = 1'b0;
    burst.push_back(r);
  endfunction

  function automatic void close_line();
    int unsigned p;
    int unsigned argc;
    bit          quoted;
    logic [7:0]  c;
    p    = 0;
    argc = 0;
    put(clet_pkg::KIND_ECHO, clet_pkg::CH_CR, 0, 1'b0);
    put(clet_pkg::KIND_ECHO, clet_pkg::CH_LF, 0, 1'b0);
    while (p < line_len && argc < ARG_CAP) begin
      quoted = 1'b0;
      while (p < line_len && is_blank(line_buf[p])) p++;
      if (p >= line_len) break;
      while (p < line_len) begin
        c = line_buf[p];
        if (c == clet_pkg::CH_QUOTE) begin
          quoted = !quoted;
          p++;
        end else if (!quoted && is_blank(c)) begin
          break;
        end else begin
          put(clet_pkg::KIND_TOKBYTE, c, argc, 1'b0);
          p++;
        end
      end
      put(clet_pkg::KIND_TOKEND, 8'h00, argc, 1'b0);
      argc++;
      if (p < line_len) p++;
    end
    put(clet_pkg::KIND_DONE, 8'h00, 0, !hangup);
    line_len = 0;
    lines_closed++;
    tokens_made += argc;
  endfunction

  function automatic void take_byte(logic [7:0] b);
    console_out_t tail;
    burst.delete();
    if (b == clet_pkg::CH_CR || b == clet_pkg::CH_LF) begin
      if (b == clet_pkg::CH_LF && cr_pending) begin
        cr_pending = 1'b0;
      end else begin
        cr_pending = (b == clet_pkg::CH_CR);
        close_line();
      end
    end else begin
      cr_pending = 1'b0;
      if (b == clet_pkg::CH_BS || b == clet_pkg::CH_DEL) begin
        if (line_len > 0) begin
          line_len--;
          erases++;
          if (echo_on) begin
            put(clet_pkg::KIND_ECHO, clet_pkg::CH_BS, 0, 1'b0);
            put(clet_pkg::KIND_ECHO, clet_pkg::CH_SP, 0, 1'b0);
            put(clet_pkg::KIND_ECHO, clet_pkg::CH_BS, 0, 1'b0);
          end
        end
      end else if (b == clet_pkg::CH_EOT) begin
        hangup = 1'b1;
      end else if (b >= clet_pkg::CH_SP && b <= clet_pkg::CH_TILDE) begin
        if (line_len < LINE_CAP) begin
          line_buf[line_len] = b;
          line_len++;
          if (echo_on) put(clet_pkg::KIND_ECHO, b, 0, 1'b0);
        end else begin
          full_drops++;
        end
      end
    end
    if (burst.size() != 0) begin
      tail = burst.pop_back();
      tail.fin = 1'b1;
      burst.push_back(tail);
    end
    foreach (burst[i]) awaited.push_back(burst[i]);
  endfunction

  function automatic string show(console_out_t r);
    return $sformatf("kind %0d byte %02h tok %0d prompt %0d disc %0d last %0d",
                     r.kind, r.data, r.tok, r.prompt, r.disc, r.fin);
  endfunction

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      rx_byte  <= 8'h00;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        take_byte(rx_byte);
        rx_done++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap != 0 && !calm) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (rx_stream.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= rx_stream.pop_front();
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk or negedge rst_n) begin
    console_out_t got;
    console_out_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {kind_w, byte_w, tok_w, prompt_w, disc_w, fin_w};
        out_done++;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: unexpected transfer: %s", show(got));
        end else begin
          want = awaited.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("ERROR: result %0d mismatch", out_done);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(got));
            end
          end
        end
      end
      if (calm) begin
        out_stall <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 17);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                 quiet, awaited.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  function automatic void queue_byte(logic [7:0] b);
    rx_stream.push_back(b);
    queued++;
  endfunction

  task automatic set_echo(bit v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    echo_on = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic settle();
    while (rx_stream.size() != 0 || in_valid || awaited.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic queue_line(int unsigned mode);
    int unsigned n;
    int unsigned i;
    int unsigned pick;
    int unsigned t;
    logic [7:0]  c;
    if (mode == 0) n = $urandom_range(LINE_CAP, LINE_CAP + 6);
    else if (mode == 1) n = $urandom_range(18, 30);
    else n = $urandom_range(0, 20);
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick == 19) begin
        c = clet_pkg::CH_QUOTE;
      end else if (pick == 18) begin
        c = ($urandom_range(0, 1) != 0) ? clet_pkg::CH_BS : clet_pkg::CH_DEL;
      end else if (pick == 17) begin
        c = 8'($urandom_range(0, 255));
        if (c == clet_pkg::CH_EOT && !eot_ok) c = 8'h1B;
      end else if (pick < ((mode == 1) ? 8 : 3)) begin
        c = clet_pkg::CH_SP;
      end else begin
        c = 8'($urandom_range(8'h21, 8'h7E));
      end
      queue_byte(c);
    end
    t = $urandom_range(0, 4);
    if (t != 1) queue_byte(clet_pkg::CH_CR);
    if (t != 0) queue_byte(clet_pkg::CH_LF);
    if (t == 4) queue_byte(clet_pkg::CH_LF);
  endtask

  task automatic queue_phase(int unsigned target, int unsigned first_mode);
    int unsigned start;
    start = queued;
    queue_line(first_mode);
    while (queued - start < target) queue_line($urandom_range(0, 9));
    settle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    set_echo(1'b1);

    queue_byte(clet_pkg::CH_DEL);
    queue_byte(clet_pkg::CH_BS);
    queue_byte(8'h00);
    queue_byte(8'hFF);
    queue_byte(8'h80);
    queue_byte(8'h1F);
    queue_byte(clet_pkg::CH_TAB);
    queue_byte(clet_pkg::CH_SP);
    queue_byte("a");
    queue_byte(clet_pkg::CH_QUOTE);
    queue_byte(clet_pkg::CH_SP);
    queue_byte(clet_pkg::CH_TILDE);
    queue_byte(clet_pkg::CH_QUOTE);
    queue_byte(clet_pkg::CH_SP);
    queue_byte("x");
    queue_byte(clet_pkg::CH_BS);
    queue_byte("y");
    queue_byte(clet_pkg::CH_CR);
    queue_byte(clet_pkg::CH_LF);
    queue_byte(clet_pkg::CH_LF);
    queue_byte(clet_pkg::CH_QUOTE);
    queue_byte(clet_pkg::CH_QUOTE);
    queue_byte(clet_pkg::CH_CR);
    queue_byte("z");
    queue_byte(clet_pkg::CH_LF);
    settle();

    set_echo(1'b0);
    queue_phase(110, 0);
    set_echo(1'b1);
    queue_phase(110, 1);
    set_echo(1'b0);
    queue_phase(50, 1);

    calm   = 1'b1;
    eot_ok = 1'b1;
    set_echo(1'b1);
    queue_byte(clet_pkg::CH_EOT);
    queue_phase(60, 0);

    $display("Covered %0d byte transfers and %0d result transfers over %0d lines, %0d tokens",
             rx_done, out_done, lines_closed, tokens_made);
    $display("Echo on and off, %0d erases, %0d bytes dropped on a full line, hang-up set %0d",
             erases, full_drops, hangup);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
